[rtl/fwkr_pkg.sv]
// Package for the keyed-removal queue: payload types, cell control and operation codes.
`default_nettype none
package fwkr_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int ITEM_BITS_DEF = 32;

    localparam logic [31:0] KEY_MASK_RST = 32'hFFFF_FFFF;

    localparam logic [2:0] K_ENQ    = 3'd0;
    localparam logic [2:0] K_DEQ    = 3'd1;
    localparam logic [2:0] K_REMOVE = 3'd2;
    localparam logic [2:0] K_REWIND = 3'd3;
    localparam logic [2:0] K_ITER   = 3'd4;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] item_value;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [31:0] item_out;
        logic [4:0]  count_out;
        logic        empty_res;
    } t_out;

    typedef struct packed {
        logic wr;
        logic deq;
        logic cmp;
        logic commit;
    } t_cell_ctl;

endpackage
`default_nettype wire

[rtl/fwkr_cell.sv]
// One queue cell: holds an entry, compares it to the key and shifts down from its neighbour.
`default_nettype none
module fwkr_cell #(
    parameter int W   = fwkr_pkg::ITEM_BITS_DEF,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire                  i_clk,
    input  fwkr_pkg::t_cell_ctl  i_ctl,
    input  wire  [CW-1:0]        i_count,
    input  wire  [CW-1:0]        i_iter,
    input  wire  [W-1:0]         i_wr_data,
    input  wire  [W-1:0]         i_key,
    input  wire  [W-1:0]         i_mask,
    input  wire  [W-1:0]         i_next_data,
    input  wire                  i_found_below,
    output logic [W-1:0]         o_data,
    output logic [W-1:0]         o_sel_data,
    output logic                 o_found,
    output logic                 o_dec
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [W-1:0] r_data;
    logic         r_hit;
    logic         w_valid;
    logic         w_match;
    logic         w_first;
    logic         w_shift;

    assign w_valid = MY_IDX < i_count;
    assign w_match = ((r_data ^ i_key) & i_mask) == '0;
    assign w_first = r_hit && !i_found_below;
    assign o_found = i_found_below || r_hit;
    assign o_dec   = w_first && (MY_IDX < i_iter);
    assign w_shift = i_ctl.deq || (i_ctl.commit && o_found);

    assign o_data     = r_data;
    assign o_sel_data = (MY_IDX == i_iter) ? r_data : '0;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (MY_IDX == i_count)) begin
            r_data <= i_wr_data;
        end else if (w_shift) begin
            r_data <= i_next_data;
        end
        if (i_ctl.cmp) begin
            r_hit <= w_valid && w_match;
        end
    end

endmodule
`default_nettype wire

[rtl/fifo_with_keyed_removal.sv]
// Top level of the bounded queue with removal by masked key and a read iterator.
`default_nettype none
// A bounded first-in-first-out queue of DEPTH item handles held in a row of cells, with
// enqueue, dequeue, remove-oldest-by-masked-key, rewind and iterate-next operations. Each
// operation gives one result word: success, item, fill count and empty flag. Enqueue,
// dequeue, rewind, iterate and the unused codes finish when accepted; remove compares
// every cell with the key in parallel, then resolves the oldest hit along the cell chain
// and closes the gap. A result word waits in the output register until it is taken, and
// while the receiver stalls it the next operation is held off; an operation is taken in
// the cycle that the waiting word leaves. The key mask resets to all ones and is written
// through its own port; the user must do so only while the block is idle (not enforced).
module fifo_with_keyed_removal #(
    parameter int DEPTH     = fwkr_pkg::DEPTH_DEF,
    parameter int ITEM_BITS = fwkr_pkg::ITEM_BITS_DEF
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  fwkr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output fwkr_pkg::t_out o_out_data,
    input  wire            i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire  [31:0]    i_cfg_data
);

    localparam int W  = (ITEM_BITS < 32) ? ITEM_BITS : 32;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REMOVE = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_iter, n_iter;
    logic [31:0]         r_key_mask;
    logic                r_out_valid;
    fwkr_pkg::t_out      r_out, n_out;
    fwkr_pkg::t_cell_ctl w_ctl;
    logic                w_acc;
    logic                w_load;
    logic                w_dec_any;
    logic [W-1:0]        w_sel_any;

    logic [W-1:0] w_data [DEPTH+1];
    logic [W-1:0] w_sel  [DEPTH];
    logic         w_dec  [DEPTH];
    logic         w_found[DEPTH+1];

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !((r_state == S_IDLE) && (!r_out_valid || !i_out_stall));
    assign w_acc       = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_found[0]    = 1'b0;
    assign w_data[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        fwkr_cell #(.W(W), .CW(CW), .IDX(g)) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_count       (r_count),
            .i_iter        (r_iter),
            .i_wr_data     (i_in_data.item_value[W-1:0]),
            .i_key         (i_in_data.item_value[W-1:0]),
            .i_mask        (r_key_mask[W-1:0]),
            .i_next_data   (w_data[g+1]),
            .i_found_below (w_found[g]),
            .o_data        (w_data[g]),
            .o_sel_data    (w_sel[g]),
            .o_found       (w_found[g+1]),
            .o_dec         (w_dec[g])
        );
    end

    always_comb begin
        w_sel_any = '0;
        w_dec_any = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            w_sel_any = w_sel_any | w_sel[i];
            w_dec_any = w_dec_any | w_dec[i];
        end
    end

    always_comb begin
        n_state          = r_state;
        n_count          = r_count;
        n_iter           = r_iter;
        w_ctl            = '0;
        w_load           = 1'b0;
        n_out            = '0;
        if (r_state == S_REMOVE) begin
            w_ctl.commit = 1'b1;
            w_load       = 1'b1;
            n_state      = S_IDLE;
            n_out.ok     = w_found[DEPTH];
            if (w_found[DEPTH]) begin
                n_count = r_count - ONE;
                if (w_dec_any) begin
                    n_iter = r_iter - ONE;
                end
            end
        end else if (w_acc) begin
            w_load = 1'b1;
            case (i_in_data.kind)
                fwkr_pkg::K_ENQ: begin
                    if (r_count != FULL) begin
                        w_ctl.wr = 1'b1;
                        n_count  = r_count + ONE;
                        n_out.ok = 1'b1;
                    end
                end
                fwkr_pkg::K_DEQ: begin
                    if (r_count != '0) begin
                        w_ctl.deq      = 1'b1;
                        n_count        = r_count - ONE;
                        n_out.ok       = 1'b1;
                        n_out.item_out = 32'(w_data[0]);
                        if (r_iter != '0) begin
                            n_iter = r_iter - ONE;
                        end
                    end
                end
                fwkr_pkg::K_REMOVE: begin
                    w_ctl.cmp = 1'b1;
                    w_load    = 1'b0;
                    n_state   = S_REMOVE;
                end
                fwkr_pkg::K_REWIND: begin
                    n_iter   = '0;
                    n_out.ok = 1'b1;
                end
                fwkr_pkg::K_ITER: begin
                    if (r_iter < r_count) begin
                        n_iter         = r_iter + ONE;
                        n_out.ok       = 1'b1;
                        n_out.item_out = 32'(w_sel_any);
                    end
                end
                default: begin
                    n_out.ok = 1'b0;
                end
            endcase
        end
        n_out.count_out = 5'(n_count);
        n_out.empty_res = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_iter      <= '0;
            r_key_mask  <= fwkr_pkg::KEY_MASK_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_iter  <= n_iter;
            if (i_cfg_valid && o_cfg_ready) begin
                r_key_mask <= i_cfg_data;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    a_remove_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |->
            $past(w_acc && (i_in_data.kind == fwkr_pkg::K_REMOVE)))
        else $error("remove phase without an accepted remove");
    a_remove_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE) |-> !r_out_valid)
        else $error("output register busy during remove");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("fill count above depth");
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter <= r_count)
        else $error("iterator beyond fill count");
`endif

endmodule
`default_nettype wire
